/* rtl/slum_pkg.sv */
`timescale 1ns / 1ps

package slum_pkg;

  // Capacity of each list
  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  // Command codes
  localparam logic [1:0] CMD_APPEND_A = 2'd0;
  localparam logic [1:0] CMD_APPEND_B = 2'd1;
  localparam logic [1:0] CMD_MERGE    = 2'd2;

  // Merge sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SKIP = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  // Status one list store hands to the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             dup_at_ptr;
  } list_stat_t;

endpackage

/* rtl/slum_list.sv */
`timescale 1ns / 1ps

module slum_list (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    wr_en_i,
  input  logic signed [slum_pkg::DATA_W-1:0]      wr_data_i,
  input  logic                                    clr_i,
  input  logic        [slum_pkg::CNT_W-1:0]       rd_ptr_i,
  output logic signed [slum_pkg::DATA_W-1:0]      rd_data_o,
  output slum_pkg::list_stat_t                    stat_o
);

  logic signed [slum_pkg::DATA_W-1:0] mem_q [slum_pkg::LIST_DEPTH];
  logic signed [slum_pkg::DATA_W-1:0] rd_q;
  logic signed [slum_pkg::DATA_W-1:0] prev_q;
  logic        [slum_pkg::LIST_DEPTH-1:0] dup_q, dup_d;
  logic        [slum_pkg::CNT_W-1:0] count_q, count_d;
  logic        [slum_pkg::IDX_W-1:0] wr_idx, prev_idx, rd_idx;
  logic                              full, do_wr;

  assign full     = (count_q == slum_pkg::CNT_W'(slum_pkg::LIST_DEPTH));
  assign do_wr    = wr_en_i && !full;
  assign wr_idx   = count_q[slum_pkg::IDX_W-1:0];
  assign prev_idx = slum_pkg::IDX_W'(count_q - slum_pkg::CNT_W'(1));
  assign rd_idx   = rd_ptr_i[slum_pkg::IDX_W-1:0];

  // Fill count
  always_comb begin
    count_d = count_q;
    if (clr_i) begin
      count_d = '0;
    end else if (do_wr) begin
      count_d = count_q + slum_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Repeat flags; an entry is flagged when its successor repeats it
  always_comb begin
    dup_d = dup_q;
    if (do_wr) begin
      dup_d[wr_idx] = 1'b0;
      if (count_q != '0) begin
        dup_d[prev_idx] = (prev_q == wr_data_i);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_idx] <= wr_data_i;
      prev_q        <= wr_data_i;
    end
    dup_q <= dup_d;
    rd_q  <= mem_q[rd_idx];
  end

  assign rd_data_o        = rd_q;
  assign stat_o.count      = count_q;
  assign stat_o.full       = full;
  assign stat_o.dup_at_ptr = dup_q[rd_idx];

endmodule

/* rtl/slum_cmp.sv */
`timescale 1ns / 1ps

module slum_cmp (
  input  logic signed [slum_pkg::DATA_W-1:0] a_i,
  input  logic signed [slum_pkg::DATA_W-1:0] b_i,
  output logic                               lt_o,
  output logic                               gt_o
);

  // Signed two's-complement compare shared by every merge step
  assign lt_o = (a_i < b_i);
  assign gt_o = (a_i > b_i);

endmodule

/* rtl/sorted_list_union_merge_top.sv */
`timescale 1ns / 1ps

// Sorted-list union merge. Command 0 or 1 appends value_i to the first or
// second list in the accepting cycle and leaves busy_o low; an append to a
// full list is dropped and flagged. Command 2 merges: busy_o stays high
// while a sequencer walks both lists with one shared signed comparator,
// collapsing runs of equal neighbours. Each repeated entry is skipped in a
// step of its own, and both lists skip in the same cycle when both sit on a
// repeat. Each emitted result takes a pointer check, then a compare on the
// registered memory read, and the merge finishes with a last pointer check
// and the closing step; merging two empty lists runs only those two steps.
// Results appear one per valid_o pulse and cannot be held off: the
// receiver must take each one in the cycle it is shown. last_o marks the
// final result, shown in the cycle in which busy_o drops, and dropped_o
// on it reports any append lost since the previous merge. Merging two
// empty lists gives no result. Both lists are empty after every merge.
module sorted_list_union_merge_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic        [1:0]                  command_i,
  input  logic signed [slum_pkg::DATA_W-1:0] value_i,
  output logic                               busy_o,
  output logic                               valid_o,
  output logic signed [slum_pkg::DATA_W-1:0] value_res_o,
  output logic                               last_o,
  output logic                               dropped_o
);

  slum_pkg::state_e     state_q, state_d;
  slum_pkg::list_stat_t stat_a, stat_b;

  logic [slum_pkg::CNT_W-1:0] a_q, a_d, b_q, b_d;
  logic signed [slum_pkg::DATA_W-1:0] rd_a, rd_b;
  logic signed [slum_pkg::DATA_W-1:0] pend_q, pend_d, out_val_q, out_val_d;
  logic pend_vld_q, pend_vld_d;
  logic out_vld_q, out_vld_d, out_last_q, out_last_d, out_drop_q, out_drop_d;
  logic ovf_q, ovf_d;
  logic accept, wr_a, wr_b, clr;
  logic a_live, b_live, lt, gt;

  assign accept = start_i && !busy_o;
  assign wr_a   = accept && (command_i == slum_pkg::CMD_APPEND_A);
  assign wr_b   = accept && (command_i == slum_pkg::CMD_APPEND_B);
  assign a_live = (a_q < stat_a.count);
  assign b_live = (b_q < stat_b.count);

  slum_list u_list_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_a),
    .wr_data_i (value_i),
    .clr_i     (clr),
    .rd_ptr_i  (a_q),
    .rd_data_o (rd_a),
    .stat_o    (stat_a)
  );

  slum_list u_list_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_b),
    .wr_data_i (value_i),
    .clr_i     (clr),
    .rd_ptr_i  (b_q),
    .rd_data_o (rd_b),
    .stat_o    (stat_b)
  );

  slum_cmp u_cmp (
    .a_i  (rd_a),
    .b_i  (rd_b),
    .lt_o (lt),
    .gt_o (gt)
  );

  // Merge sequencer
  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_vld_d  = 1'b0;
    out_val_d  = out_val_q;
    out_last_d = 1'b0;
    out_drop_d = 1'b0;
    ovf_d      = ovf_q;
    clr        = 1'b0;
    unique case (state_q)
      slum_pkg::ST_IDLE: begin
        if ((wr_a && stat_a.full) || (wr_b && stat_b.full)) begin
          ovf_d = 1'b1;
        end
        if (accept && (command_i == slum_pkg::CMD_MERGE)) begin
          a_d        = '0;
          b_d        = '0;
          pend_vld_d = 1'b0;
          state_d    = slum_pkg::ST_SKIP;
        end
      end
      slum_pkg::ST_SKIP: begin
        // step past repeated neighbours, one entry per cycle
        if (a_live && stat_a.dup_at_ptr) begin
          a_d = a_q + slum_pkg::CNT_W'(1);
        end
        if (b_live && stat_b.dup_at_ptr) begin
          b_d = b_q + slum_pkg::CNT_W'(1);
        end
        if (!(a_live && stat_a.dup_at_ptr) && !(b_live && stat_b.dup_at_ptr)) begin
          if (!a_live && !b_live) begin
            state_d = slum_pkg::ST_FIN;
          end else begin
            state_d = slum_pkg::ST_CMP;
          end
        end
      end
      slum_pkg::ST_CMP: begin
        // pick the next union item; hold it until the one after is known
        if (a_live && b_live) begin
          if (lt) begin
            pend_d = rd_a;
            a_d    = a_q + slum_pkg::CNT_W'(1);
          end else if (gt) begin
            pend_d = rd_b;
            b_d    = b_q + slum_pkg::CNT_W'(1);
          end else begin
            pend_d = rd_b;
            a_d    = a_q + slum_pkg::CNT_W'(1);
            b_d    = b_q + slum_pkg::CNT_W'(1);
          end
        end else if (a_live) begin
          pend_d = rd_a;
          a_d    = a_q + slum_pkg::CNT_W'(1);
        end else begin
          pend_d = rd_b;
          b_d    = b_q + slum_pkg::CNT_W'(1);
        end
        pend_vld_d = 1'b1;
        if (pend_vld_q) begin
          out_vld_d = 1'b1;
          out_val_d = pend_q;
        end
        state_d = slum_pkg::ST_SKIP;
      end
      slum_pkg::ST_FIN: begin
        if (pend_vld_q) begin
          out_vld_d  = 1'b1;
          out_val_d  = pend_q;
          out_last_d = 1'b1;
          out_drop_d = ovf_q;
        end
        pend_vld_d = 1'b0;
        ovf_d      = 1'b0;
        clr        = 1'b1;
        state_d    = slum_pkg::ST_IDLE;
      end
      default: begin
        state_d = slum_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= slum_pkg::ST_IDLE;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_drop_q <= 1'b0;
      ovf_q      <= 1'b0;
      a_q        <= '0;
      b_q        <= '0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
      out_drop_q <= out_drop_d;
      ovf_q      <= ovf_d;
      a_q        <= a_d;
      b_q        <= b_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_q    <= pend_d;
    out_val_q <= out_val_d;
  end

  assign busy_o      = (state_q != slum_pkg::ST_IDLE);
  assign valid_o     = out_vld_q;
  assign value_res_o = out_val_q;
  assign last_o      = out_last_q;
  assign dropped_o   = out_drop_q;

endmodule

/* rtl/slum_checker.sv */
`timescale 1ns / 1ps

module slum_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic [1:0] command_i,
  input logic       busy_i,
  input logic       valid_i,
  input logic       last_i,
  input logic       dropped_i
);

  // A merge item always occupies the block
  a_merge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && (command_i == slum_pkg::CMD_MERGE) |=> busy_i)
    else $error("merge accepted but block not busy");

  // last and dropped only ride on a result
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_i |-> valid_i)
    else $error("last without result strobe");

  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_i |-> last_i)
    else $error("dropped outside the last result");

  // more results follow a non-final one
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !last_i |-> busy_i)
    else $error("non-final result while idle");

  // final result ends the merge
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && last_i |-> !busy_i)
    else $error("busy after final result");

endmodule

bind sorted_list_union_merge_top slum_checker u_slum_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .command_i (command_i),
  .busy_i    (busy_o),
  .valid_i   (valid_o),
  .last_i    (last_o),
  .dropped_i (dropped_o)
);
